// ===== rtl/core/printer_packet_receiver_defines.svh =====
// assertion macros used by the printer packet receiver rtl
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef PRINTER_PACKET_RECEIVER_DEFINES_SVH
`define PRINTER_PACKET_RECEIVER_DEFINES_SVH

// property checked at every clock edge outside reset
`define PPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ppr_pkg.sv =====
// shared types, constants and helpers for the printer packet receiver
// no dependencies
package ppr_pkg;

  localparam logic [7:0] MagicFirst          = 8'h88;
  localparam logic [7:0] MagicSecond         = 8'h33;
  localparam logic [7:0] AckByte             = 8'h81;
  localparam logic [7:0] StatusChecksumError = 8'h01;

  localparam logic [7:0] CmdInit   = 8'h01;
  localparam logic [7:0] CmdPrint  = 8'h02;
  localparam logic [7:0] CmdData   = 8'h04;
  localparam logic [7:0] CmdStatus = 8'h0F;

  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic [7:0]  command_code;
    logic        checksum_ok;
    logic        packet_done;
    logic [15:0] payload_index;
    logic        payload_valid;
    logic [7:0]  tx_byte;
  } result_t;

  localparam int unsigned ResultWidth = $bits(result_t);

  function automatic logic known_command(logic [7:0] c);
    return (c == CmdInit) || (c == CmdPrint) || (c == CmdData) || (c == CmdStatus);
  endfunction

endpackage

// ===== rtl/core/ppr_framer.sv =====
// front part: packet framer that steps once per accepted byte
// depends on ppr_pkg and printer_packet_receiver_defines.svh
`include "printer_packet_receiver_defines.svh"
module ppr_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output ppr_pkg::result_t  result_o
);
  import ppr_pkg::*;

  localparam logic [3:0] PhMagic0 = 4'd0;
  localparam logic [3:0] PhMagic1 = 4'd1;
  localparam logic [3:0] PhCmd    = 4'd2;
  localparam logic [3:0] PhComp   = 4'd3;
  localparam logic [3:0] PhLen0   = 4'd4;
  localparam logic [3:0] PhLen1   = 4'd5;
  localparam logic [3:0] PhData   = 4'd6;
  localparam logic [3:0] PhSum0   = 4'd7;
  localparam logic [3:0] PhSum1   = 4'd8;
  localparam logic [3:0] PhAck0   = 4'd9;
  localparam logic [3:0] PhAck1   = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  magic_q, magic_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  chk_lo_q, chk_lo_d;
  logic [7:0]  status_q, status_d;
  logic [15:0] sum_add;
  logic [15:0] count_inc;
  logic [15:0] len_full;

  assign sum_add   = sum_q + {8'h00, rx_byte_i};
  assign count_inc = count_q + 16'd1;
  assign len_full  = {rx_byte_i, len_q[7:0]};

  always_comb begin
    phase_d  = phase_q;
    magic_d  = magic_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    count_d  = count_q;
    sum_d    = sum_q;
    chk_lo_d = chk_lo_q;
    status_d = status_q;
    result_o = '0;
    case (phase_q)
      PhMagic0: begin
        magic_d = rx_byte_i;
        phase_d = PhMagic1;
      end
      PhMagic1: begin
        phase_d = (magic_q == MagicFirst && rx_byte_i == MagicSecond) ? PhCmd : PhMagic0;
      end
      PhCmd: begin
        cmd_d   = rx_byte_i;
        sum_d   = {8'h00, rx_byte_i};
        phase_d = known_command(rx_byte_i) ? PhComp : PhMagic0;
      end
      PhComp: begin
        sum_d   = sum_add;
        phase_d = PhLen0;
      end
      PhLen0: begin
        len_d   = {8'h00, rx_byte_i};
        sum_d   = sum_add;
        phase_d = PhLen1;
      end
      PhLen1: begin
        len_d   = len_full;
        sum_d   = sum_add;
        count_d = '0;
        phase_d = (len_full != 16'd0) ? PhData : PhSum0;
      end
      PhData: begin
        result_o.payload_valid = 1'b1;
        result_o.payload_index = count_q;
        sum_d   = sum_add;
        count_d = count_inc;
        if (count_inc == len_q) begin
          phase_d = PhSum0;
        end
      end
      PhSum0: begin
        chk_lo_d = rx_byte_i;
        phase_d  = PhSum1;
      end
      PhSum1: begin
        status_d = ({rx_byte_i, chk_lo_q} == sum_q) ? 8'h00 : StatusChecksumError;
        count_d  = '0;
        phase_d  = PhAck0;
      end
      PhAck0: begin
        result_o.tx_byte = AckByte;
        phase_d = PhAck1;
      end
      PhAck1: begin
        result_o.tx_byte      = status_q;
        result_o.packet_done  = 1'b1;
        result_o.checksum_ok  = ((status_q & StatusChecksumError) == 8'h00);
        result_o.command_code = cmd_q;
        phase_d = PhMagic0;
      end
      default: begin
        phase_d = PhMagic0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhMagic0;
      magic_q  <= '0;
      cmd_q    <= '0;
      len_q    <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      chk_lo_q <= '0;
      status_q <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      magic_q  <= magic_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      chk_lo_q <= chk_lo_d;
      status_q <= status_d;
    end
  end

  `PPR_ASSERT(a_data_nonzero_len, (phase_q == PhData) |-> (len_q != 16'd0), "data phase with zero length")
  `PPR_ASSERT(a_data_in_range, (phase_q == PhData) |-> (count_q < len_q), "payload count past length")
  `PPR_ASSERT_NEXT(a_data_end, accept_i && phase_q == PhData && count_inc == len_q, phase_q == PhSum0, "payload end missed")
  `PPR_ASSERT_NEXT(a_ack1_restart, accept_i && phase_q == PhAck1, phase_q == PhMagic0, "framer not back at start")

endmodule

// ===== rtl/core/ppr_queue.sv =====
// back part: short result queue that drives the output channel
// depends on ppr_pkg
module ppr_queue #(
  parameter int unsigned Depth = ppr_pkg::QueueDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ppr_pkg::result_t  push_data_i,
  output logic              has_space_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output ppr_pkg::result_t  pop_data_o
);
  import ppr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  result_t           mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign has_space_o = (count_q != FullCnt);
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rptr_q];
  assign do_push     = push_i && has_space_o;
  assign do_pop      = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/printer_packet_receiver.sv =====
// top level of the printer packet receiver
// depends on ppr_pkg, ppr_framer and ppr_queue
//
// Slave side of a byte-serial printer link. Each transfer on the slave
// channel carries one host byte; each transfer on the master channel
// carries the answer for that byte: the reply byte, a payload flag with
// its index inside the packet, and on the final reply slot the packet
// end (tlast), the checksum result and the command code.
// The framer steps once per accepted byte, so one byte is taken every
// cycle while the queue has space; its result is registered in a small
// queue and shown on the master channel once older results are taken.
// The queue holds QueueDepth results; while the master side stalls the
// slave side keeps taking bytes until the queue is full, then drops
// tready until a result is taken. With the default depth of two the
// channel sustains one transfer per cycle while the master side does not stall.
// Reset clears the framer to waiting for the first magic byte and
// empties the queue.
module printer_packet_receiver #(
  parameter int unsigned QueueDepth = ppr_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // tx_byte[7:0], payload_index[23:8], command_code[31:24]
  output logic [1:0]  m_axis_tuser_o,   // payload_valid[0], checksum_ok[1]
  output logic        m_axis_tlast_o    // packet_done
);
  import ppr_pkg::*;

  logic    accept;
  result_t step_res;
  result_t out_res;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  ppr_framer u_framer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata_i),
    .result_o  (step_res)
  );

  ppr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (step_res),
    .has_space_o (s_axis_tready_o),
    .pop_valid_o (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .pop_data_o  (out_res)
  );

  assign m_axis_tdata_o = {out_res.command_code, out_res.payload_index, out_res.tx_byte};
  assign m_axis_tuser_o = {out_res.checksum_ok, out_res.payload_valid};
  assign m_axis_tlast_o = out_res.packet_done;

endmodule

// ===== dv/testbench.sv =====
// self-checking bench for printer_packet_receiver: byte stream in, one reply per byte out
// uses ppr_pkg for the command and reply codes and the result layout, and instantiates printer_packet_receiver
// stimulus is framed packets with random content plus broken headers, checked by a local framer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ppr_pkg::*;

  typedef enum logic [3:0] {
    WAIT_MAGIC0,
    WAIT_MAGIC1,
    GET_CMD,
    GET_COMP,
    GET_LEN0,
    GET_LEN1,
    GET_DATA,
    GET_SUM0,
    GET_SUM1,
    SEND_ACK,
    SEND_STATUS
  } frame_phase_e;

  localparam logic [7:0] KnownCmds [4] = '{CmdInit, CmdPrint, CmdData, CmdStatus};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  printer_packet_receiver DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  // host byte stream and replies still owed by the block
  logic [7:0] host_bytes [$];
  result_t    expected_replies [$];

  // local framer state
  frame_phase_e phase = WAIT_MAGIC0;
  logic [7:0]   magic_hold = '0;
  logic [7:0]   pkt_cmd = '0;
  logic [7:0]   pkt_comp = '0;
  logic [15:0]  pkt_len = '0;
  logic [15:0]  data_count = '0;
  logic [15:0]  sum_acc = '0;
  logic [15:0]  got_sum = '0;
  logic [7:0]   status_byte = '0;

  int bytes_taken = 0;
  int replies_checked = 0;
  int packets_closed = 0;
  int packets_bad_sum = 0;
  int payload_bytes = 0;
  int mismatch_count = 0;

  logic byte_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   sink_tick = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  task automatic frame_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (phase)
      WAIT_MAGIC0: begin
        magic_hold = b;
        phase = WAIT_MAGIC1;
      end
      WAIT_MAGIC1: begin
        phase = (magic_hold == MagicFirst && b == MagicSecond) ? GET_CMD : WAIT_MAGIC0;
      end
      GET_CMD: begin
        pkt_cmd = b;
        sum_acc = {8'h00, b};
        phase = (b inside {CmdInit, CmdPrint, CmdData, CmdStatus}) ? GET_COMP : WAIT_MAGIC0;
      end
      GET_COMP: begin
        pkt_comp = b;
        sum_acc = sum_acc + {8'h00, b};
        phase = GET_LEN0;
      end
      GET_LEN0: begin
        pkt_len = {8'h00, b};
        sum_acc = sum_acc + {8'h00, b};
        phase = GET_LEN1;
      end
      GET_LEN1: begin
        pkt_len[15:8] = b;
        sum_acc = sum_acc + {8'h00, b};
        data_count = '0;
        phase = (pkt_len != 0) ? GET_DATA : GET_SUM0;
      end
      GET_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_index = data_count;
        sum_acc = sum_acc + {8'h00, b};
        data_count = data_count + 16'd1;
        payload_bytes++;
        if (data_count == pkt_len) phase = GET_SUM0;
      end
      GET_SUM0: begin
        got_sum = {8'h00, b};
        phase = GET_SUM1;
      end
      GET_SUM1: begin
        got_sum[15:8] = b;
        status_byte = (got_sum == sum_acc) ? 8'h00 : StatusChecksumError;
        data_count = '0;
        phase = SEND_ACK;
      end
      SEND_ACK: begin
        r.tx_byte = AckByte;
        phase = SEND_STATUS;
      end
      SEND_STATUS: begin
        r.tx_byte = status_byte;
        r.packet_done = 1'b1;
        r.checksum_ok = ((status_byte & StatusChecksumError) == 0);
        r.command_code = pkt_cmd;
        packets_closed++;
        if (!r.checksum_ok) packets_bad_sum++;
        phase = WAIT_MAGIC0;
      end
      default: begin
        phase = WAIT_MAGIC0;
      end
    endcase
    expected_replies.push_back(r);
  endtask

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic queue_packet(input logic [7:0] cmd, input logic [7:0] comp,
                              input logic [15:0] len, input logic sum_bad);
    logic [15:0] sum;
    logic [7:0]  d;
    sum = {8'h00, cmd} + {8'h00, comp} + {8'h00, len[7:0]} + {8'h00, len[15:8]};
    host_bytes.push_back(MagicFirst);
    host_bytes.push_back(MagicSecond);
    host_bytes.push_back(cmd);
    host_bytes.push_back(comp);
    host_bytes.push_back(len[7:0]);
    host_bytes.push_back(len[15:8]);
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      host_bytes.push_back(d);
      sum = sum + {8'h00, d};
    end
    if (sum_bad) sum = sum ^ 16'($urandom_range(1, 65535));
    host_bytes.push_back(sum[7:0]);
    host_bytes.push_back(sum[15:8]);
    host_bytes.push_back(8'($urandom));
    host_bytes.push_back(8'($urandom));
  endtask

  // input transfers feed the framer, output transfers are checked
  always @(posedge clk_i) begin
    byte_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      frame_byte(s_axis_tdata_i);
      bytes_taken++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_replies.size() == 0) begin
        $error("reply transfer with no byte outstanding");
        mismatch_count++;
      end else begin
        result_t want;
        want = expected_replies.pop_front();
        compare_field("tx_byte", 16'(want.tx_byte), 16'(m_axis_tdata_o[7:0]));
        compare_field("payload_index", want.payload_index, m_axis_tdata_o[23:8]);
        compare_field("command_code", 16'(want.command_code), 16'(m_axis_tdata_o[31:24]));
        compare_field("payload_valid", 16'(want.payload_valid), 16'(m_axis_tuser_o[0]));
        compare_field("checksum_ok", 16'(want.checksum_ok), 16'(m_axis_tuser_o[1]));
        compare_field("packet_done", 16'(want.packet_done), 16'(m_axis_tlast_o));
      end
      replies_checked++;
    end
  end

  // host side: bursts of bytes with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && !byte_taken) begin
        // hold the current byte until it is taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (host_bytes.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= host_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // reply side: stall pattern rotates through four modes, one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      sink_tick <= sink_tick + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!hold_done && replies_checked >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 80;
        m_axis_tready_i <= 1'b0;
      end else begin
        case ((sink_tick / 40) % 4)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= (sink_tick % 4) != 3;
          2: m_axis_tready_i <= 1'($urandom_range(0, 1));
          default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [7:0] first;
    logic [7:0] second;
    int         kind;

    // broken headers, then zero length with a good sum and one byte with a bad sum
    host_bytes.push_back(MagicFirst);
    host_bytes.push_back(8'h34);
    host_bytes.push_back(8'h00);
    host_bytes.push_back(MagicSecond);
    host_bytes.push_back(MagicFirst);
    host_bytes.push_back(MagicSecond);
    host_bytes.push_back(8'h03);
    queue_packet(CmdInit, 8'hFF, 16'd0, 1'b0);
    queue_packet(CmdStatus, 8'h00, 16'd1, 1'b1);

    while (host_bytes.size() < 470) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        first = ($urandom_range(0, 1) == 0) ? MagicFirst : 8'($urandom);
        second = 8'($urandom);
        if (first == MagicFirst && second == MagicSecond) second = 8'hFF;
        host_bytes.push_back(first);
        host_bytes.push_back(second);
      end else if (kind == 1) begin
        first = 8'($urandom);
        if (first inside {CmdInit, CmdPrint, CmdData, CmdStatus}) first = first ^ 8'h80;
        host_bytes.push_back(MagicFirst);
        host_bytes.push_back(MagicSecond);
        host_bytes.push_back(first);
      end else begin
        queue_packet(KnownCmds[$urandom_range(0, 3)], 8'($urandom),
                     ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 80))
                                                 : 16'($urandom_range(0, 12)),
                     $urandom_range(0, 4) == 0);
      end
    end
    // one packet with a nonzero upper length byte, then a short one
    queue_packet(CmdData, 8'($urandom), 16'd260, 1'b0);
    queue_packet(CmdPrint, 8'($urandom), 16'd3, 1'b0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (host_bytes.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (expected_replies.size() != 0) begin
      $error("%0d replies never arrived", expected_replies.size());
      mismatch_count++;
    end
    $display("covered %0d host bytes and %0d replies, %0d payload bytes",
             bytes_taken, replies_checked, payload_bytes);
    $display("%0d packets closed, %0d of them with a checksum error",
             packets_closed, packets_bad_sum);
    if (mismatch_count == 0) begin
      $display("printer_packet_receiver verification clean");
    end else begin
      $display("printer_packet_receiver verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("printer_packet_receiver verification failed");
    $finish;
  end

endmodule
